FILE: design/signed_int_to_decimal_ascii_defines.svh
// Assertion macros shared by the RTL of the decimal text converter
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// Property checked at every clock edge outside reset
`define SITDA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked in the cycle after its antecedent
`define SITDA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/sitda_pkg.sv
package sitda_pkg;

	localparam int VALUE_W = 32;
	localparam int CHAR_W  = 7;
	localparam int CAND_W  = 34;

	localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;
	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
	localparam logic [3:0]        TOP_POW     = 4'd9;
	localparam logic [1:0]        STEP_LAST   = 2'd3;
	localparam logic [3:0]        DIGIT_MAX   = 4'd9;

	typedef enum logic {
		ST_IDLE,
		ST_DIGIT
	} state_t;

	// Trial value for one bit of a decimal digit: 10^pw weighted 8, 4, 2, 1
	function automatic logic [CAND_W-1:0] pow_mult(input logic [3:0] pw, input logic [1:0] st);
		logic [CAND_W-1:0] base;
		case (pw)
			4'd0:    base = 34'd1;
			4'd1:    base = 34'd10;
			4'd2:    base = 34'd100;
			4'd3:    base = 34'd1000;
			4'd4:    base = 34'd10000;
			4'd5:    base = 34'd100000;
			4'd6:    base = 34'd1000000;
			4'd7:    base = 34'd10000000;
			4'd8:    base = 34'd100000000;
			4'd9:    base = 34'd1000000000;
			default: base = 34'd0;
		endcase
		return base << (STEP_LAST - st);
	endfunction

endpackage

FILE: design/signed_int_to_decimal_ascii.sv
// Channel  | Ports                        | Handshake
// request  | start, busy, value           | taken when start && !busy
// result   | strobe, char_code, last_char | one strobe per character, no stall
//
// A request is worked after the accept: each of the ten decimal places costs
// four compare-subtract steps of the single 34-bit unit.
// The sign character goes out on the cycle after accept; a digit goes out on the
// cycle after its place's last step, so busy falls as the final character shows.
// Asynchronous active-low reset returns the sequencer to idle.
// The receiver cannot stall; results are never held back.
module signed_int_to_decimal_ascii (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [sitda_pkg::VALUE_W-1:0] value,
	output logic                                strobe,
	output logic [sitda_pkg::CHAR_W-1:0]        char_code,
	output logic                                last_char
);
	import sitda_pkg::*;

	`include "signed_int_to_decimal_ascii_defines.svh"

	state_t              state_q, state_d;
	logic [3:0]          pow_q;
	logic [1:0]          step_q;
	logic [VALUE_W-1:0]  rem_q;
	logic [2:0]          dig_q;
	logic                started_q;
	logic                strobe_q;
	logic [CHAR_W-1:0]   char_q;
	logic                last_q;

	logic                accept;
	logic [CAND_W-1:0]   cand;
	logic [CAND_W-1:0]   diff;
	logic                ge;
	logic [3:0]          dig_full;
	logic                emit;
	logic                done;
	logic [VALUE_W-1:0]  mag;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign strobe    = strobe_q;
	assign char_code = char_q;
	assign last_char = last_q;

	// Magnitude; the most negative value wraps to 0x80000000, as wanted
	assign mag = value[VALUE_W-1] ? (~value + 1'b1) : value;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_DIGIT;
			end
			ST_DIGIT: begin
				if (done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Shared compare-subtract unit and digit decisions
	always_comb begin
		cand     = pow_mult(pow_q, step_q);
		diff     = {2'b00, rem_q} - cand;
		ge       = ({2'b00, rem_q} >= cand);
		dig_full = {dig_q, ge};
		done     = (state_q == ST_DIGIT) && (step_q == STEP_LAST) && (pow_q == 4'd0);
		emit     = (state_q == ST_DIGIT) && (step_q == STEP_LAST)
			&& (started_q || (dig_full != 4'd0) || (pow_q == 4'd0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			strobe_q  <= 1'b0;
			started_q <= 1'b0;
			pow_q     <= '0;
			step_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				pow_q     <= TOP_POW;
				step_q    <= '0;
				started_q <= 1'b0;
				strobe_q  <= value[VALUE_W-1];
			end else if (state_q == ST_DIGIT) begin
				step_q    <= step_q + 2'd1;
				if (step_q == STEP_LAST) pow_q <= pow_q - 4'd1;
				started_q <= started_q || emit;
				strobe_q  <= emit;
			end else begin
				strobe_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			rem_q  <= mag;
			dig_q  <= '0;
			char_q <= ASCII_MINUS;
			last_q <= 1'b0;
		end else if (state_q == ST_DIGIT) begin
			if (ge) rem_q <= diff[VALUE_W-1:0];
			dig_q <= (step_q == STEP_LAST) ? 3'd0 : dig_full[2:0];
			if (emit) begin
				char_q <= ASCII_ZERO + {3'b000, dig_full};
				last_q <= (pow_q == 4'd0);
			end
		end
	end

	`SITDA_ASSERT(a_last_ends_busy, !(strobe && last_char) || !busy,
		"final character shown while still busy")
	`SITDA_ASSERT(a_char_legal, !strobe || (char_code == ASCII_MINUS)
		|| ((char_code >= ASCII_ZERO) && (char_code <= ASCII_ZERO + 7'd9)),
		"character is neither minus nor a digit")
	`SITDA_ASSERT(a_digit_range, !((state_q == ST_DIGIT) && (step_q == STEP_LAST))
		|| (dig_full <= DIGIT_MAX), "decimal digit above nine")
	`SITDA_ASSERT_NEXT(a_sign_first, accept && value[VALUE_W-1],
		strobe && (char_code == ASCII_MINUS) && !last_char,
		"negative request did not open with minus")

endmodule

FILE: sim/tb_signed_int_to_decimal_ascii.sv
module tb_signed_int_to_decimal_ascii;

	timeunit 1ns;
	timeprecision 1ps;

	import sitda_pkg::*;

	localparam int N_DIRECTED   = 20;
	localparam int N_RANDOM     = 160;
	localparam int N_PHASES     = 4;
	localparam int MAX_PLACES   = 10;
	localparam int DRAIN_CYCLES = 60;

	// One character of the decimal text
	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} text_char_t;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic signed [VALUE_W-1:0] value;
	logic                      strobe;
	logic [CHAR_W-1:0]         char_code;
	logic                      last_char;

	text_char_t pending_chars[$];
	int         mismatches;

	signed_int_to_decimal_ascii i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.strobe    (strobe),
		.char_code (char_code),
		.last_char (last_char)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Overall time limit
	initial begin
		#2ms;
		$display("FAIL signed_int_to_decimal_ascii");
		$finish;
	end

	// Predictor: sign, then digits of the 33-bit magnitude, most significant first
	function automatic void push_decimal_text(input logic [VALUE_W-1:0] v);
		logic [VALUE_W:0] mag;
		logic [3:0]       digits [MAX_PLACES];
		int               ndig;
		text_char_t       ch;
		mag  = v[VALUE_W-1] ? (({(VALUE_W+1){1'b0}}) - {1'b1, v}) : {1'b0, v};
		ndig = 0;
		do begin
			digits[ndig] = 4'(mag % 33'd10);
			ndig++;
			mag = mag / 33'd10;
		end while (mag != 0 && ndig < MAX_PLACES);
		if (v[VALUE_W-1]) begin
			ch.code = ASCII_MINUS;
			ch.last = 1'b0;
			pending_chars.push_back(ch);
		end
		for (int i = ndig - 1; i >= 0; i--) begin
			ch.code = ASCII_ZERO + CHAR_W'(digits[i]);
			ch.last = (i == 0);
			pending_chars.push_back(ch);
		end
	endfunction

	// Present one request, wait for it to be taken, then queue its text
	task automatic send_value(input logic [VALUE_W-1:0] v, input string text, input int idle_pct);
		text_char_t ch;
		while ($urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
		if (text.len() == 0) begin
			push_decimal_text(v);
		end else begin
			for (int i = 0; i < text.len(); i++) begin
				ch.code = CHAR_W'(text[i]);
				ch.last = (i == text.len() - 1);
				pending_chars.push_back(ch);
			end
		end
	endtask

	// Random value: full range, small, near a power of ten, extremes or random width
	function automatic logic [VALUE_W-1:0] random_value();
		logic [VALUE_W-1:0] r;
		int unsigned        p;
		case ($urandom_range(7, 0))
			0, 1, 2: r = $urandom;
			3:       r = $urandom_range(99, 0);
			4: begin
				p = 1;
				repeat ($urandom_range(9, 0)) p = p * 10;
				r = p + $urandom_range(2, 0) - 1;
			end
			5:       r = $urandom_range(1, 0) ? 32'h7fff_ffff : 32'h8000_0000;
			default: r = $urandom >> $urandom_range(31, 0);
		endcase
		if ($urandom_range(1, 0)) r = -r;
		return r;
	endfunction

	// Result checker: every strobe must match the oldest pending character
	always @(posedge clk) begin
		text_char_t exp_ch;
		if (arst_n && strobe) begin
			if (pending_chars.size() == 0) begin
				$error("unexpected character: char_code %0d last_char %0b", char_code, last_char);
				mismatches++;
			end else begin
				exp_ch = pending_chars.pop_front();
				if (char_code !== exp_ch.code) begin
					$error("char_code: expected %0d, actual %0d", exp_ch.code, char_code);
					mismatches++;
				end
				if (last_char !== exp_ch.last) begin
					$error("last_char: expected %0b, actual %0b", exp_ch.last, last_char);
					mismatches++;
				end
			end
		end
	end

	// Stimulus
	initial begin
		logic [VALUE_W-1:0] dir_value [N_DIRECTED];
		string              dir_text  [N_DIRECTED];
		int                 idle_pct  [N_PHASES];
		mismatches = 0;
		// empty text: checked against the predictor
		dir_value = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'h7fff_ffff,
			32'h8000_0000, 32'h8000_0001, 32'd1000000000, 32'd999999999,
			-32'sd999999999, 32'd100, 32'd12345, -32'sd987654321, 32'h5555_5555,
			32'haaaa_aaaa, 32'd1999999999, 32'h8000_0000, 32'd0};
		dir_text  = '{"0", "1", "-1", "9", "10", "-10", "2147483647",
			"-2147483648", "-2147483647", "1000000000", "999999999",
			"-999999999", "", "", "", "",
			"", "", "-2147483648", "0"};
		idle_pct  = '{0, 88, 0, 37};

		arst_n <= 1'b0;
		start  <= 1'b0;
		value  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, back to back
		for (int i = 0; i < N_DIRECTED; i++)
			send_value(dir_value[i], dir_text[i], 0);

		// random requests across the idling phases
		for (int ph = 0; ph < N_PHASES; ph++)
			for (int i = 0; i < N_RANDOM / N_PHASES; i++)
				send_value(random_value(), "", idle_pct[ph]);
		start <= 1'b0;

		// drain
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_chars.size() == 0) begin
			$display("PASS signed_int_to_decimal_ascii");
		end else begin
			$display("FAIL signed_int_to_decimal_ascii");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+design
design/sitda_pkg.sv
design/signed_int_to_decimal_ascii.sv
sim/tb_signed_int_to_decimal_ascii.sv
